>>> hw/rtl/wheel_gyro_odometry_assert.svh
// Assertion macros shared by the odometry pipeline.
`ifndef WHEEL_GYRO_ODOMETRY_ASSERT_SVH
`define WHEEL_GYRO_ODOMETRY_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define WGO_ASSERT_NOW(label, clock, reset, trig, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define WGO_ASSERT_NEXT(label, clock, reset, trig, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> hw/rtl/wgo_pkg.sv
// Shared types and constants of the wheel and gyro odometry pipeline.
`default_nettype none

package wgo_pkg;

  typedef enum logic [2:0] {
    KIND_TICK         = 3'd0,
    KIND_CAL_START    = 3'd1,
    KIND_CLR_DIST     = 3'd2,
    KIND_CLR_HEADING  = 3'd3,
    KIND_LOAD_HEADING = 3'd4
  } kind_t;

  localparam logic [0:0] REG_MM_PER_COUNT  = 1'b0;
  localparam logic [0:0] REG_CALIB_INTERVAL = 1'b1;

  localparam logic [19:0] MM_PER_COUNT_RESET = 20'd0;
  localparam logic [7:0]  CALIB_INTERVAL_RESET = 8'd5;

  // Division by 1000 for operands below 2^31: ceil(2^41 / 1000).
  localparam int          HDIV_SHIFT = 41;
  localparam logic [31:0] HDIV_RECIP = 32'd2199023256;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] rate;
    logic [7:0]         tms;
    logic [13:0]        right;
    logic [13:0]        left;
    logic signed [39:0] angle;
  } in_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] rate;
    logic signed [39:0] angle;
    logic signed [16:0] rd;
    logic signed [16:0] ld;
    logic signed [39:0] pd;
    logic signed [32:0] ph;
    logic               cal_done;
    logic signed [31:0] cal_sum;
    logic               busy;
  } s2_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] rate;
    logic signed [39:0] angle;
    logic signed [16:0] rd;
    logic signed [16:0] ld;
    logic signed [39:0] dinc;
    logic signed [22:0] hinc;
    logic               cal_done;
    logic signed [23:0] offq;
    logic               busy;
  } s3_t;

endpackage

`default_nettype wire

>>> hw/rtl/wheel_gyro_odometry.sv
// Top level of the wheel and gyro odometry block.
`default_nettype none
`include "wheel_gyro_odometry_assert.svh"

// The block takes one request per clock cycle while in_stall is low and returns
// one result per request, in order, through a four-register pipeline: input
// register, a stage that forms the wheel deltas, the calibration state and the
// two products, a stage that performs the divisions by reciprocal
// multiplication, and the accumulator stage that holds the result. Each
// register moves on when the next one is empty or moving, so the input keeps
// taking requests while a finished result waits, until all four registers are
// full. Configuration writes take effect at once and should be made while no
// request is in flight. No clearing pass follows reset.
module wheel_gyro_odometry #(
  parameter int ENC_BITS      = 14,
  parameter int CALIB_SAMPLES = 100
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         kind,
  input  wire logic signed [23:0] gyro_rate,
  input  wire logic [7:0]         tick_ms,
  input  wire logic [13:0]        right_angle,
  input  wire logic [13:0]        left_angle,
  input  wire logic signed [39:0] angle_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [39:0]      distance,
  output logic signed [39:0]      heading,
  output logic signed [24:0]      rate_corrected,
  output logic signed [23:0]      offset_out,
  output logic                    calib_busy,
  output logic signed [14:0]      right_delta,
  output logic signed [14:0]      left_delta
);

  logic [19:0] mm_per_count;
  logic [7:0]  calib_interval;

  logic v1;
  logic v2;
  logic v3;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;
  logic fire1;
  logic fire2;
  logic fire3;

  wgo_pkg::in_t s1;
  wgo_pkg::s2_t s2;
  wgo_pkg::s3_t s3;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign fire1    = v1 && rdy2;
  assign fire2    = v2 && rdy3;
  assign fire3    = v3 && rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_per_count   <= wgo_pkg::MM_PER_COUNT_RESET;
      calib_interval <= wgo_pkg::CALIB_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wgo_pkg::REG_MM_PER_COUNT:   mm_per_count   <= cfg_data;
        wgo_pkg::REG_CALIB_INTERVAL: calib_interval <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1.kind  <= wgo_pkg::kind_t'(kind);
      s1.rate  <= gyro_rate;
      s1.tms   <= tick_ms;
      s1.right <= right_angle;
      s1.left  <= left_angle;
      s1.angle <= angle_value;
    end
  end

  wgo_front #(
    .ENC_BITS      (ENC_BITS),
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire1),
    .s1             (s1),
    .mm_per_count   (mm_per_count),
    .calib_interval (calib_interval),
    .s2             (s2)
  );

  wgo_divide #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_divide (
    .clk  (clk),
    .fire (fire2),
    .s2   (s2),
    .s3   (s3)
  );

  wgo_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire3),
    .s3             (s3),
    .distance       (distance),
    .heading        (heading),
    .rate_corrected (rate_corrected),
    .offset_out     (offset_out),
    .calib_busy     (calib_busy),
    .right_delta    (right_delta),
    .left_delta     (left_delta)
  );

  // The input stalls only when every pipeline register holds a request.
  `WGO_ASSERT_NOW(a_stall_only_when_full, clk, rst, in_stall, v1 && v2 && v3 && out_valid, "input stalled with room in the pipeline")
  // A request in the divide stage reaches the output when there is room for it.
  `WGO_ASSERT_NEXT(a_stage3_drains, clk, rst, v3 && rdy4, out_valid, "request lost between the divide stage and the output")
  // A finished calibration never reports itself as still running.
  `WGO_ASSERT_NOW(a_done_not_busy, clk, rst, v3 && s3.cal_done, !s3.busy, "calibration finished while still marked busy")

endmodule

`default_nettype wire

>>> hw/rtl/wgo_front.sv
// First stage: wheel deltas, gyro calibration state and the two products.
`default_nettype none

module wgo_front #(
  parameter int ENC_BITS      = 14,
  parameter int CALIB_SAMPLES = 100
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fire,
  input  wire wgo_pkg::in_t s1,
  input  wire logic [19:0]  mm_per_count,
  input  wire logic [7:0]   calib_interval,
  output wgo_pkg::s2_t      s2
);

  localparam logic [ENC_BITS:0]   FULL = {1'b1, {ENC_BITS{1'b0}}};
  localparam logic [ENC_BITS-1:0] HALF = {1'b1, {(ENC_BITS - 1){1'b0}}};
  localparam logic [6:0]          CAL_TARGET = 7'(CALIB_SAMPLES);

  logic [ENC_BITS-1:0] prev_right;
  logic [ENC_BITS-1:0] prev_left;
  logic                calib_active;
  logic [6:0]          calib_count;
  logic signed [31:0]  calib_sum;
  logic [8:0]          calib_timer;

  logic [31:0]              r_ext;
  logic [31:0]              l_ext;
  logic [ENC_BITS-1:0]      r_now;
  logic [ENC_BITS-1:0]      l_now;
  logic [ENC_BITS-1:0]      dr_raw;
  logic [ENC_BITS-1:0]      dl_raw;
  logic signed [ENC_BITS:0] rd;
  logic signed [ENC_BITS:0] ld;
  logic signed [ENC_BITS+1:0] diff;
  logic signed [ENC_BITS+22:0] pd;
  logic signed [32:0]       ph;
  logic                     is_tick;

  logic               active_next;
  logic [6:0]         count_next;
  logic signed [31:0] sum_next;
  logic [8:0]         timer_next;
  logic [8:0]         timer_add;
  logic               done;

  always_comb begin
    is_tick = (s1.kind == wgo_pkg::KIND_TICK);
    r_ext   = 32'(s1.right);
    l_ext   = 32'(s1.left);
    r_now   = r_ext[ENC_BITS-1:0];
    l_now   = l_ext[ENC_BITS-1:0];
    dr_raw  = r_now - prev_right;
    dl_raw  = l_now - prev_left;
    rd = '0;
    ld = '0;
    if (is_tick) begin
      rd = (dr_raw > HALF) ? $signed({1'b0, dr_raw} - FULL) : $signed({1'b0, dr_raw});
      ld = (dl_raw > HALF) ? $signed({1'b0, dl_raw} - FULL) : $signed({1'b0, dl_raw});
    end
    diff = $signed({rd[ENC_BITS], rd}) - $signed({ld[ENC_BITS], ld});
    pd   = diff * $signed({1'b0, mm_per_count});
    ph   = s1.rate * $signed({1'b0, s1.tms});
  end

  always_comb begin
    active_next = calib_active;
    count_next  = calib_count;
    sum_next    = calib_sum;
    timer_next  = calib_timer;
    timer_add   = calib_timer + 9'(s1.tms);
    done        = 1'b0;
    if (is_tick) begin
      if (calib_active) begin
        if (timer_add >= 9'(calib_interval)) begin
          timer_next = '0;
          sum_next   = calib_sum + 32'(s1.rate);
          count_next = calib_count + 7'd1;
          if (count_next >= CAL_TARGET) begin
            done        = 1'b1;
            active_next = 1'b0;
          end
        end else begin
          timer_next = timer_add;
        end
      end
    end else if (s1.kind == wgo_pkg::KIND_CAL_START) begin
      active_next = 1'b1;
      count_next  = '0;
      sum_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_right   <= '0;
      prev_left    <= '0;
      calib_active <= 1'b0;
      calib_count  <= '0;
      calib_sum    <= '0;
      calib_timer  <= '0;
    end else if (fire) begin
      if (is_tick) begin
        prev_right <= r_now;
        prev_left  <= l_now;
      end
      calib_active <= active_next;
      calib_count  <= count_next;
      calib_sum    <= sum_next;
      calib_timer  <= timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s2.kind     <= s1.kind;
      s2.rate     <= s1.rate;
      s2.angle    <= s1.angle;
      s2.rd       <= 17'(rd);
      s2.ld       <= 17'(ld);
      s2.pd       <= 40'(pd);
      s2.ph       <= ph;
      s2.cal_done <= done;
      s2.cal_sum  <= sum_next;
      s2.busy     <= active_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wgo_divide.sv
// Second stage: truncating divisions by 2, by 1000 and by the sample count.
`default_nettype none

module wgo_divide #(
  parameter int CALIB_SAMPLES = 100
) (
  input  wire logic         clk,
  input  wire logic         fire,
  input  wire wgo_pkg::s2_t s2,
  output wgo_pkg::s3_t      s3
);

  // Exact reciprocal for magnitudes below 2^30.
  localparam int          CAL_SHIFT = 30 + $clog2(CALIB_SAMPLES);
  localparam logic [63:0] CAL_RECIP_FULL =
    ((64'd1 << CAL_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam logic [30:0] CAL_RECIP = CAL_RECIP_FULL[30:0];

  logic               h_neg;
  logic [32:0]        h_abs;
  logic [30:0]        h_mag;
  logic [62:0]        h_prod;
  logic [21:0]        h_quot;
  logic signed [22:0] hinc;

  logic signed [39:0] d_sum;
  logic signed [39:0] dinc;

  logic               o_neg;
  logic [31:0]        o_abs;
  logic [29:0]        o_mag;
  logic [60:0]        o_prod;
  logic [60:0]        o_shift;
  logic [29:0]        o_quot;
  logic [30:0]        o_signed;

  always_comb begin
    h_neg  = s2.ph[32];
    h_abs  = h_neg ? 33'(-s2.ph) : 33'(s2.ph);
    h_mag  = h_abs[30:0];
    h_prod = h_mag * wgo_pkg::HDIV_RECIP;
    h_quot = h_prod[62:wgo_pkg::HDIV_SHIFT];
    hinc   = h_neg ? -$signed({1'b0, h_quot}) : $signed({1'b0, h_quot});

    d_sum = s2.pd + $signed({39'd0, s2.pd[39]});
    dinc  = d_sum >>> 1;

    o_neg    = s2.cal_sum[31];
    o_abs    = o_neg ? 32'(-s2.cal_sum) : 32'(s2.cal_sum);
    o_mag    = o_abs[29:0];
    o_prod   = o_mag * CAL_RECIP;
    o_shift  = o_prod >> CAL_SHIFT;
    o_quot   = o_shift[29:0];
    o_signed = o_neg ? (31'd0 - {1'b0, o_quot}) : {1'b0, o_quot};
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s3.kind     <= s2.kind;
      s3.rate     <= s2.rate;
      s3.angle    <= s2.angle;
      s3.rd       <= s2.rd;
      s3.ld       <= s2.ld;
      s3.dinc     <= dinc;
      s3.hinc     <= hinc;
      s3.cal_done <= s2.cal_done;
      s3.offq     <= $signed(o_signed[23:0]);
      s3.busy     <= s2.busy;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wgo_accum.sv
// Last stage: saturating distance and heading accumulators and the result register.
`default_nettype none

module wgo_accum (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fire,
  input  wire wgo_pkg::s3_t s3,
  output logic signed [39:0] distance,
  output logic signed [39:0] heading,
  output logic signed [24:0] rate_corrected,
  output logic signed [23:0] offset_out,
  output logic               calib_busy,
  output logic signed [14:0] right_delta,
  output logic signed [14:0] left_delta
);

  localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

  logic signed [39:0] distance_acc;
  logic signed [39:0] heading_acc;
  logic signed [23:0] last_rate;
  logic signed [23:0] rate_offset;

  logic signed [39:0] distance_next;
  logic signed [39:0] heading_next;
  logic signed [23:0] last_rate_next;
  logic signed [23:0] rate_offset_next;

  function automatic logic signed [39:0] sat_add(input logic signed [39:0] a,
                                                 input logic signed [40:0] b);
    logic signed [40:0] s;
    s = 41'(a) + b;
    if (s[40] != s[39]) begin
      sat_add = s[40] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = s[39:0];
    end
  endfunction

  always_comb begin
    distance_next    = distance_acc;
    heading_next     = heading_acc;
    last_rate_next   = last_rate;
    rate_offset_next = s3.cal_done ? s3.offq : rate_offset;
    unique case (s3.kind)
      wgo_pkg::KIND_TICK: begin
        distance_next  = sat_add(distance_acc, 41'(s3.dinc));
        heading_next   = sat_add(heading_acc, 41'(s3.hinc));
        last_rate_next = s3.rate;
      end
      wgo_pkg::KIND_CLR_DIST: begin
        distance_next = '0;
      end
      wgo_pkg::KIND_CLR_HEADING: begin
        heading_next = '0;
      end
      wgo_pkg::KIND_LOAD_HEADING: begin
        heading_next = s3.angle;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_acc <= '0;
      heading_acc  <= '0;
      last_rate    <= '0;
      rate_offset  <= '0;
    end else if (fire) begin
      distance_acc <= distance_next;
      heading_acc  <= heading_next;
      last_rate    <= last_rate_next;
      rate_offset  <= rate_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rate_corrected <= 25'(last_rate_next) - 25'(rate_offset_next);
      calib_busy     <= s3.busy;
      right_delta    <= s3.rd[14:0];
      left_delta     <= s3.ld[14:0];
    end
  end

  assign distance   = distance_acc;
  assign heading    = heading_acc;
  assign offset_out = rate_offset;

endmodule

`default_nettype wire

>>> verif/odometry_checker.sv
// Checker that predicts every odometry result and compares it with the block.
`timescale 1ns / 100ps

module odometry_checker
  import wgo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         kind,
  input  logic signed [23:0] gyro_rate,
  input  logic [7:0]         tick_ms,
  input  logic [13:0]        right_angle,
  input  logic [13:0]        left_angle,
  input  logic signed [39:0] angle_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [39:0] distance,
  input  logic signed [39:0] heading,
  input  logic signed [24:0] rate_corrected,
  input  logic signed [23:0] offset_out,
  input  logic               calib_busy,
  input  logic signed [14:0] right_delta,
  input  logic signed [14:0] left_delta,
  output int                 mismatches,
  output int                 in_flight
);

  localparam int CAL_SAMPLES = 100;
  localparam longint ACC_MAX = 64'sd549755813887;
  localparam longint ACC_MIN = -64'sd549755813888;

  typedef struct {
    logic signed [39:0] distance;
    logic signed [39:0] heading;
    logic signed [24:0] rate_corrected;
    logic signed [23:0] offset;
    logic               busy;
    logic signed [14:0] rd;
    logic signed [14:0] ld;
  } odometry_t;

  odometry_t pending_results[$];

  longint mm_per_count;
  int     cal_interval;
  logic [13:0] prev_right;
  logic [13:0] prev_left;
  longint distance_acc;
  longint heading_acc;
  longint last_rate;
  longint rate_offset;
  longint cal_sum;
  bit     cal_active;
  int     cal_count;
  int     cal_timer;

  function automatic longint wheel_delta(logic [13:0] now, logic [13:0] prev);
    logic [13:0] d;
    d = now - prev;
    return (d > 14'd8192) ? longint'(d) - 64'sd16384 : longint'(d);
  endfunction

  function automatic longint clamp40(longint s);
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s;
  endfunction

  task automatic clear_state();
    mm_per_count = MM_PER_COUNT_RESET;
    cal_interval = CALIB_INTERVAL_RESET;
    prev_right = '0;
    prev_left = '0;
    distance_acc = 0;
    heading_acc = 0;
    last_rate = 0;
    rate_offset = 0;
    cal_sum = 0;
    cal_active = 0;
    cal_count = 0;
    cal_timer = 0;
  endtask

  task automatic advance_odometry(output odometry_t res);
    longint rate;
    longint rd;
    longint ld;
    rd = 0;
    ld = 0;
    case (kind)
      KIND_TICK: begin
        rate = gyro_rate;
        last_rate = rate;
        if (cal_active) begin
          cal_timer = (cal_timer + int'(tick_ms)) & 'h1FF;
          if (cal_timer >= cal_interval) begin
            cal_timer = 0;
            cal_sum += rate;
            cal_count = (cal_count + 1) & 'h7F;
            if (cal_count >= CAL_SAMPLES) begin
              rate_offset = cal_sum / CAL_SAMPLES;
              cal_active = 0;
            end
          end
        end
        rd = wheel_delta(right_angle, prev_right);
        ld = wheel_delta(left_angle, prev_left);
        distance_acc = clamp40(distance_acc + ((rd - ld) * mm_per_count) / 2);
        heading_acc = clamp40(heading_acc + (rate * longint'(tick_ms)) / 1000);
        prev_right = right_angle;
        prev_left = left_angle;
      end
      KIND_CAL_START: begin
        cal_active = 1;
        cal_count = 0;
        cal_sum = 0;
      end
      KIND_CLR_DIST: distance_acc = 0;
      KIND_CLR_HEADING: heading_acc = 0;
      KIND_LOAD_HEADING: heading_acc = angle_value;
      default: ;
    endcase
    res.distance = distance_acc[39:0];
    res.heading = heading_acc[39:0];
    res.rate_corrected = 25'(last_rate - rate_offset);
    res.offset = rate_offset[23:0];
    res.busy = cal_active;
    res.rd = rd[14:0];
    res.ld = ld[14:0];
  endtask

  task automatic check_field(string name, logic signed [39:0] want,
                             logic signed [39:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    odometry_t want;
    if (rst) begin
      clear_state();
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MM_PER_COUNT: mm_per_count = cfg_data;
          REG_CALIB_INTERVAL: cal_interval = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_odometry(want);
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("Result arrived with no request waiting.");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("distance", want.distance, distance);
          check_field("heading", want.heading, heading);
          check_field("rate_corrected", want.rate_corrected, rate_corrected);
          check_field("offset_out", want.offset, offset_out);
          check_field("calib_busy", want.busy, calib_busy);
          check_field("right_delta", want.rd, right_delta);
          check_field("left_delta", want.ld, left_delta);
        end
      end
    end
    in_flight <= pending_results.size();
  end

endmodule

>>> verif/tb_wheel_gyro_odometry.sv
// Testbench top that drives requests, configuration and stalls into the odometry block.
`timescale 1ns / 100ps

module tb_wheel_gyro_odometry;
  import wgo_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]         kind;
    logic signed [23:0] rate;
    logic [7:0]         tms;
    logic [13:0]        right;
    logic [13:0]        left;
    logic signed [39:0] angle;
  } odo_req_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [19:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         kind = '0;
  logic signed [23:0] gyro_rate = '0;
  logic [7:0]         tick_ms = '0;
  logic [13:0]        right_angle = '0;
  logic [13:0]        left_angle = '0;
  logic signed [39:0] angle_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [39:0] distance;
  logic signed [39:0] heading;
  logic signed [24:0] rate_corrected;
  logic signed [23:0] offset_out;
  logic               calib_busy;
  logic signed [14:0] right_delta;
  logic signed [14:0] left_delta;
  int                 mismatches;
  int                 in_flight;

  int          cycle_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_cycles = 0;
  logic [13:0] last_right = '0;
  logic [13:0] last_left = '0;
  int          streak_fwd = 0;
  int          streak_back = 0;

  wheel_gyro_odometry u_top (.*);

  odometry_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_wheel_gyro_odometry failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_cycles <= 59;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (!hold_req) hold_taken <= 1'b0;
    end
  end

  function automatic odo_req_t mk_request(logic [2:0] k, logic signed [23:0] rate,
                                          logic [7:0] tms, logic [13:0] r,
                                          logic [13:0] l, logic signed [39:0] ang);
    odo_req_t rq;
    rq.kind = k;
    rq.rate = rate;
    rq.tms = tms;
    rq.right = r;
    rq.left = l;
    rq.angle = ang;
    return rq;
  endfunction

  function automatic logic signed [23:0] pick_rate();
    int p;
    int v;
    p = $urandom_range(0, 99);
    v = int'($urandom_range(0, 2000)) - 1000;
    if (p < 50) return 24'(v);
    if (p < 90) return 24'($urandom);
    if (p < 95) return 24'sh7FFFFF;
    return 24'sh800000;
  endfunction

  function automatic logic [7:0] pick_tms();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 8'($urandom_range(0, 8));
    if (p < 85) return 8'($urandom_range(0, 255));
    if (p < 93) return 8'd0;
    return 8'd255;
  endfunction

  function automatic logic [13:0] pick_wheel(logic [13:0] prev);
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return prev + 14'($urandom_range(0, 400)) - 14'd200;
    if (p < 90) return 14'($urandom);
    if (p < 95) return prev + 14'd8192;
    return prev + 14'd8193;
  endfunction

  function automatic logic signed [39:0] pick_heading();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 40'({$urandom, $urandom});
    if (p < 75) return 40'sh7F_FFFF_FFFF - 40'($urandom_range(0, 4000000));
    return 40'sh80_0000_0000 + 40'($urandom_range(0, 4000000));
  endfunction

  task automatic rand_request(output odo_req_t rq);
    int p;
    rq.rate = pick_rate();
    rq.tms = pick_tms();
    rq.angle = pick_heading();
    rq.right = pick_wheel(last_right);
    rq.left = pick_wheel(last_left);
    p = $urandom_range(0, 999);
    if (streak_fwd > 0) begin
      streak_fwd--;
      rq.kind = KIND_TICK;
      rq.right = last_right + 14'd8192;
      rq.left = last_left - 14'd8191;
    end else if (streak_back > 0) begin
      streak_back--;
      rq.kind = KIND_TICK;
      rq.right = last_right - 14'd8191;
      rq.left = last_left + 14'd8192;
    end else if (p < 5) begin
      rq.kind = KIND_CAL_START;
    end else if (p < 25) begin
      rq.kind = KIND_CLR_DIST;
    end else if (p < 45) begin
      rq.kind = KIND_CLR_HEADING;
    end else if (p < 65) begin
      rq.kind = KIND_LOAD_HEADING;
    end else if (p < 72) begin
      rq.kind = 3'($urandom_range(5, 7));
    end else begin
      rq.kind = KIND_TICK;
    end
  endtask

  task automatic send_request(input odo_req_t rq);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    kind <= rq.kind;
    gyro_rate <= rq.rate;
    tick_ms <= rq.tms;
    right_angle <= rq.right;
    left_angle <= rq.left;
    angle_value <= rq.angle;
    if (rq.kind == KIND_TICK) begin
      last_right = rq.right;
      last_left = rq.left;
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [19:0] mm, input logic [7:0] interval);
    cfg_we <= 1'b1;
    cfg_index <= REG_MM_PER_COUNT;
    cfg_data <= mm;
    @(posedge clk);
    cfg_index <= REG_CALIB_INTERVAL;
    cfg_data <= {12'd0, interval};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [19:0] mm, input logic [7:0] interval,
                           input int gap, input int stall, input int count,
                           input bit with_streak);
    odo_req_t rq;
    wait_for_results();
    configure(mm, interval);
    send_gap_pct = gap;
    recv_stall_pct <= stall;
    if (with_streak) begin
      streak_fwd = 70;
      streak_back = 140;
    end
    send_request(mk_request(KIND_CAL_START, pick_rate(), pick_tms(), 14'($urandom),
                            14'($urandom), pick_heading()));
    repeat (count) begin
      rand_request(rq);
      send_request(rq);
    end
  endtask

  initial begin : stimulus
    odo_req_t rq;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The first requests run on the reset configuration.
    send_request(mk_request(KIND_TICK, 24'sd5, 8'd10, 14'd0, 14'd0, '0));
    send_request(mk_request(KIND_TICK, 24'sd300, 8'd20, 14'd100, 14'd50, '0));
    wait_for_results();
    configure(20'hFFFFF, 8'd0);

    send_request(mk_request(KIND_TICK, 24'sd0, 8'd0, 14'd0, 14'd0, '0));
    send_request(mk_request(KIND_TICK, 24'sd10, 8'd1, 14'd8192, 14'd16383, '0));
    send_request(mk_request(KIND_TICK, 24'sd10, 8'd1, 14'd1, 14'd8191, '0));
    send_request(mk_request(KIND_TICK, 24'sh7FFFFF, 8'd255, 14'd1, 14'd8191, '0));
    send_request(mk_request(KIND_TICK, 24'sh800000, 8'd255, 14'd1, 14'd8191, '0));
    send_request(mk_request(KIND_TICK, -24'sd1, 8'd7, 14'd1, 14'd8191, '0));
    send_request(mk_request(KIND_LOAD_HEADING, pick_rate(), 8'd3, 14'd5, 14'd5,
                            40'sh7F_FFFF_FFFF));
    send_request(mk_request(KIND_TICK, 24'sh7FFFFF, 8'd255, 14'd1, 14'd8191, '0));
    send_request(mk_request(KIND_LOAD_HEADING, pick_rate(), 8'd3, 14'd5, 14'd5,
                            40'sh80_0000_0000));
    send_request(mk_request(KIND_TICK, 24'sh800000, 8'd255, 14'd1, 14'd8191, '0));
    send_request(mk_request(KIND_CLR_HEADING, pick_rate(), 8'd9, 14'd7, 14'd7, '1));
    send_request(mk_request(KIND_CLR_DIST, pick_rate(), 8'd9, 14'd7, 14'd7, '1));
    send_request(mk_request(KIND_CAL_START, pick_rate(), 8'd9, 14'd7, 14'd7, '1));
    send_request(mk_request(KIND_TICK, 24'sd1234, 8'd0, 14'd16383, 14'd0, '0));
    send_request(mk_request(KIND_TICK, -24'sd999, 8'd3, 14'd16383, 14'd0, '0));
    send_request(mk_request(KIND_CAL_START, pick_rate(), 8'd9, 14'd7, 14'd7, '0));
    send_request(mk_request(KIND_TICK, 24'sd77, 8'd1, 14'd16000, 14'd300, '0));
    send_request(mk_request(3'd5, pick_rate(), 8'd9, 14'd7, 14'd7, '1));
    send_request(mk_request(3'd7, pick_rate(), 8'd9, 14'd7, 14'd7, '1));
    send_request(mk_request(KIND_TICK, pick_rate(), 8'd0, 14'd16000, 14'd300, '0));

    run_phase(20'($urandom_range(1, 1048574)), 8'd5, 0, 0, 300, 1'b0);
    run_phase(20'd0, 8'd255, 82, 0, 300, 1'b0);
    run_phase(20'($urandom_range(1, 1048574)), 8'd1, 0, 82, 300, 1'b0);
    run_phase(20'hFFFFF, 8'($urandom_range(2, 254)), 23, 23, 300, 1'b1);

    // The receiver holds off while requests keep coming, so the pipeline fills.
    wait_for_results();
    configure(20'($urandom_range(1, 1048574)), 8'($urandom_range(1, 255)));
    send_gap_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= 1'b1;
    repeat (30) begin
      rand_request(rq);
      send_request(rq);
    end
    hold_req <= 1'b0;

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_wheel_gyro_odometry passed");
    end else begin
      $display("tb_wheel_gyro_odometry failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/wgo_pkg.sv
hw/rtl/wgo_front.sv
hw/rtl/wgo_divide.sv
hw/rtl/wgo_accum.sv
hw/rtl/wheel_gyro_odometry.sv
verif/odometry_checker.sv
verif/tb_wheel_gyro_odometry.sv
